// ===== rtl/rhc_pkg.sv =====
// Shared widths and stage payload types for the RGB to HSV converter.
package rhc_pkg;

    // Channel and result widths.
    localparam int CH_W     = 8;
    localparam int HUE_BITS = 16;
    localparam int SAT_BITS = 16;

    // Hue numerator is below 6 * 255, so it fits in 11 bits, as does 6 * delta.
    localparam int NUM_W = 11;
    localparam int DH_W  = NUM_W;

    // Hue dividend is num << HUE_BITS; its reciprocal uses 2^(HUE_BITS + NUM_W).
    localparam int KH   = HUE_BITS + NUM_W;
    localparam int RH_W = KH - 2;

    // Saturation dividend is delta * (2^SAT_BITS - 1); reciprocal of max uses 2^XS_W.
    localparam int XS_W = SAT_BITS + CH_W;
    localparam int RS_W = XS_W + 1;

    localparam int PH_W = NUM_W + RH_W;
    localparam int PS_W = XS_W + RS_W;

    localparam int TAB_N = 1 << CH_W;
    localparam int NSTG  = 5;

    localparam int IN_W  = ((3 * CH_W + 7) / 8) * 8;
    localparam int OUT_W = ((HUE_BITS + SAT_BITS + CH_W + 7) / 8) * 8;

    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  delta;
        logic [NUM_W-1:0] num;
        logic [DH_W-1:0]  dh;
        logic             hz;
        logic             sz;
    } t_s1;

    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [NUM_W-1:0] num;
        logic [DH_W-1:0]  dh;
        logic [XS_W-1:0]  xs;
        logic [RH_W-1:0]  rh;
        logic [RS_W-1:0]  rs;
        logic             hz;
        logic             sz;
    } t_s2;

    typedef struct packed {
        logic [CH_W-1:0]     mx;
        logic [NUM_W-1:0]    num;
        logic [DH_W-1:0]     dh;
        logic [XS_W-1:0]     xs;
        logic [HUE_BITS-1:0] q0h;
        logic [SAT_BITS-1:0] q0s;
        logic                hz;
        logic                sz;
    } t_s3;

    typedef struct packed {
        logic [CH_W-1:0]     mx;
        logic [DH_W-1:0]     dh;
        logic [HUE_BITS-1:0] q0h;
        logic [SAT_BITS-1:0] q0s;
        logic [DH_W:0]       remh;
        logic [CH_W:0]       rems;
        logic                hz;
        logic                sz;
    } t_s4;

    typedef struct packed {
        logic [CH_W-1:0]     value;
        logic [SAT_BITS-1:0] sat;
        logic [HUE_BITS-1:0] hue;
    } t_s5;

endpackage

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// Top level of the RGB to HSV converter: a five-stage pixel pipeline.
//
// One RGB pixel comes in on the s_axis channel per transfer and one HSV result
// leaves on the m_axis channel per transfer, in the same order. The input word
// carries red, green and blue bytes from the low bits up; the output word carries
// hue, saturation and value from the low bits up, zero padded to whole bytes.
//
// The datapath has five register stages. While the receiver keeps tready high,
// the block takes and delivers one pixel every cycle. Stage one finds max, min,
// delta and the hue sector; stage two reads the reciprocal tables; stage three
// multiplies the dividends by the reciprocals; stage four forms the remainders;
// the output stage applies the final plus-one correction.
//
// Every stage carries its own valid bit and advances when the stage after it is
// empty or moving, so a stall on m_axis holds the result in the output register
// and lets the earlier stages fill up; s_axis_tready falls only when all five
// stages hold pixels. Nothing is dropped or repeated under a stall.
//
// Reset (i_rst_n low at a clock edge) clears all valid bits; the pipeline comes
// out of reset empty and ready.
module rgb_to_hsv_converter_unit
    import rhc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // red, green, blue
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // hue, saturation, value, zero pad
);

    // Valid bit of each stage, and the per-stage advance enables.
    logic [NSTG:1] r_v;
    logic [NSTG:1] n_v;
    logic [NSTG+1:1] w_adv;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;

    // Reciprocal tables: floor(2^KH / (6 * i)) for hue, floor(2^XS_W / i) for
    // saturation. Entry zero is never used for a real quotient.
    logic [RH_W-1:0] w_tab_h [0:TAB_N-1];
    logic [RS_W-1:0] w_tab_s [0:TAB_N-1];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
        localparam longint unsigned DEN_H = (gi == 0) ? 1 : 6 * gi;
        localparam longint unsigned DEN_S = (gi == 0) ? 1 : gi;
        localparam longint unsigned RH_V  = (gi == 0) ? 0 : (64'd1 << KH) / DEN_H;
        localparam longint unsigned RS_V  = (gi == 0) ? 0 : (64'd1 << XS_W) / DEN_S;
        assign w_tab_h[gi] = RH_W'(RH_V);
        assign w_tab_s[gi] = RS_W'(RS_V);
    end

    // A stage can take a new item when it is empty or its item moves on.
    always_comb begin
        w_adv[NSTG+1] = m_axis_tready;
        for (int k = NSTG; k >= 1; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign s_axis_tready = w_adv[1];

    always_comb begin
        n_v[1] = s_axis_tvalid;
        for (int k = 2; k <= NSTG; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    // Stage one: max, min, delta and the sector numerator.
    logic [CH_W-1:0]  w_r, w_g, w_b;
    logic [CH_W-1:0]  w_mx, w_mn;
    logic [NUM_W-1:0] w_d, w_d6;

    always_comb begin
        w_r = s_axis_tdata[CH_W-1:0];
        w_g = s_axis_tdata[2*CH_W-1:CH_W];
        w_b = s_axis_tdata[3*CH_W-1:2*CH_W];

        w_mx = w_r;
        if (w_g > w_mx) begin
            w_mx = w_g;
        end
        if (w_b > w_mx) begin
            w_mx = w_b;
        end
        w_mn = w_r;
        if (w_g < w_mn) begin
            w_mn = w_g;
        end
        if (w_b < w_mn) begin
            w_mn = w_b;
        end

        n_s1.mx    = w_mx;
        n_s1.delta = w_mx - w_mn;
        w_d        = NUM_W'(n_s1.delta);
        w_d6       = NUM_W'(6 * w_d);
        n_s1.dh    = w_d6;
        n_s1.hz    = (n_s1.delta == '0);
        n_s1.sz    = (w_mx == '0);

        // Ties go to red, then green. The arithmetic wraps in NUM_W bits, and the
        // final value always lies in [0, 6 * delta).
        if (w_r == w_mx) begin
            if (w_g >= w_b) begin
                n_s1.num = NUM_W'(w_g) - NUM_W'(w_b);
            end else begin
                n_s1.num = w_d6 + NUM_W'(w_g) - NUM_W'(w_b);
            end
        end else if (w_g == w_mx) begin
            n_s1.num = NUM_W'(2 * w_d) + NUM_W'(w_b) - NUM_W'(w_r);
        end else begin
            n_s1.num = NUM_W'(4 * w_d) + NUM_W'(w_r) - NUM_W'(w_g);
        end
    end

    // Stage two: table reads and the saturation dividend.
    always_comb begin
        n_s2.mx  = r_s1.mx;
        n_s2.num = r_s1.num;
        n_s2.dh  = r_s1.dh;
        n_s2.xs  = (XS_W'(r_s1.delta) << SAT_BITS) - XS_W'(r_s1.delta);
        n_s2.rh  = w_tab_h[r_s1.delta];
        n_s2.rs  = w_tab_s[r_s1.mx];
        n_s2.hz  = r_s1.hz;
        n_s2.sz  = r_s1.sz;
    end

    // Stage three: estimate quotients, which are low by at most one.
    logic [PH_W-1:0] w_ph;
    logic [PS_W-1:0] w_ps;

    always_comb begin
        w_ph     = PH_W'(r_s2.num) * PH_W'(r_s2.rh);
        w_ps     = PS_W'(r_s2.xs) * PS_W'(r_s2.rs);
        n_s3.mx  = r_s2.mx;
        n_s3.num = r_s2.num;
        n_s3.dh  = r_s2.dh;
        n_s3.xs  = r_s2.xs;
        n_s3.q0h = w_ph[NUM_W +: HUE_BITS];
        n_s3.q0s = w_ps[XS_W +: SAT_BITS];
        n_s3.hz  = r_s2.hz;
        n_s3.sz  = r_s2.sz;
    end

    // Stage four: remainders of the estimates, each below twice the divisor.
    logic [KH-1:0]   w_xh, w_mh, w_rh;
    logic [XS_W-1:0] w_ms, w_rs;

    always_comb begin
        w_xh      = {r_s3.num, {HUE_BITS{1'b0}}};
        w_mh      = KH'(r_s3.q0h) * KH'(r_s3.dh);
        w_rh      = w_xh - w_mh;
        w_ms      = XS_W'(r_s3.q0s) * XS_W'(r_s3.mx);
        w_rs      = r_s3.xs - w_ms;
        n_s4.mx   = r_s3.mx;
        n_s4.dh   = r_s3.dh;
        n_s4.q0h  = r_s3.q0h;
        n_s4.q0s  = r_s3.q0s;
        n_s4.remh = w_rh[DH_W:0];
        n_s4.rems = w_rs[CH_W:0];
        n_s4.hz   = r_s3.hz;
        n_s4.sz   = r_s3.sz;
    end

    // Output stage: correct the estimate, force zero for grey and black pixels.
    always_comb begin
        n_s5.value = r_s4.mx;
        if (r_s4.hz) begin
            n_s5.hue = '0;
        end else begin
            n_s5.hue = r_s4.q0h + HUE_BITS'(r_s4.remh >= {1'b0, r_s4.dh});
        end
        if (r_s4.sz) begin
            n_s5.sat = '0;
        end else begin
            n_s5.sat = r_s4.q0s + SAT_BITS'(r_s4.rems >= {1'b0, r_s4.mx});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NSTG; k++) begin
                if (w_adv[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1 <= n_s1;
        end
        if (w_adv[2]) begin
            r_s2 <= n_s2;
        end
        if (w_adv[3]) begin
            r_s3 <= n_s3;
        end
        if (w_adv[4]) begin
            r_s4 <= n_s4;
        end
        if (w_adv[5]) begin
            r_s5 <= n_s5;
        end
    end

    assign m_axis_tvalid = r_v[NSTG];
    assign m_axis_tdata  = OUT_W'(r_s5);

endmodule

// ===== rtl/rhc_checker.sv =====
// Port-level assertions for the RGB to HSV converter, bound to the top level.
module rhc_checker
    import rhc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata
);

    logic w_s_xfer;
    logic [HUE_BITS-1:0] w_hue;
    logic [SAT_BITS-1:0] w_sat;
    logic [CH_W-1:0]     w_val;

    assign w_s_xfer = s_axis_tvalid && s_axis_tready;
    assign w_hue    = m_axis_tdata[HUE_BITS-1:0];
    assign w_sat    = m_axis_tdata[HUE_BITS +: SAT_BITS];
    assign w_val    = m_axis_tdata[HUE_BITS+SAT_BITS +: CH_W];

    // A held result keeps its valid and its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The pipeline comes out of reset empty.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Zero saturation means a grey pixel, whose hue is zero.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_sat == '0) |-> (w_hue == '0))
        else $error("nonzero hue with zero saturation");

    // A black pixel has zero saturation.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_val == '0) |-> (w_sat == '0))
        else $error("nonzero saturation for black pixel");

    // With the receiver ready after a transfer, a valid result is expected on m_axis.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_xfer ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (.*);
